[hdl/register_write_datagram_framer_defines.svh]
// Assertion macros for the register write datagram framer.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef REGISTER_WRITE_DATAGRAM_FRAMER_DEFINES_SVH
`define REGISTER_WRITE_DATAGRAM_FRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RWDF_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`define RWDF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define RWDF_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)
`define RWDF_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

[hdl/rwdf_pkg.sv]
// Shared types, constants and the CRC-8 byte update of the datagram framer.
// Depends on nothing.
package rwdf_pkg;

  localparam logic [7:0] SYNC_RESET = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] POS_SYNC  = 3'd0;
  localparam logic [2:0] POS_NODE  = 3'd1;
  localparam logic [2:0] POS_REG   = 3'd2;
  localparam logic [2:0] POS_DATA3 = 3'd3;
  localparam logic [2:0] POS_DATA2 = 3'd4;
  localparam logic [2:0] POS_DATA1 = 3'd5;
  localparam logic [2:0] POS_DATA0 = 3'd6;
  localparam logic [2:0] POS_CRC   = 3'd7;

  typedef struct packed {
    logic [7:0]  sync;
    logic [7:0]  node;
    logic [7:0]  reg_byte;
    logic [31:0] data;
  } frame_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic [2:0] pos;
  } back_status_t;

  // Feeds one byte into the CRC, least significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] crc;
    logic [7:0] cur;
    logic       fb;
    crc = crc_in;
    cur = din;
    for (int b = 0; b < 8; b++) begin
      fb  = crc[7] ^ cur[0];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      cur = {1'b0, cur[7:1]};
    end
    return crc;
  endfunction

endpackage

[hdl/rwdf_if.sv]
// Channel interfaces of the datagram framer: write requests in, bytes out.
// Depends on nothing.
interface rwdf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  node_address;
  logic [6:0]  register_address;
  logic [31:0] data_word;
  modport source(output valid, output node_address, output register_address,
                 output data_word, input ready);
  modport sink(input valid, input node_address, input register_address,
               input data_word, output ready);
endinterface

interface rwdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source(output valid, output out_byte, output last_byte, input ready);
  modport sink(input valid, input out_byte, input last_byte, output ready);
endinterface

[hdl/rwdf_front.sv]
// Front part: holds the sync byte register, accepts requests and formats them.
// Depends on rwdf_pkg and rwdf_req_if.
module rwdf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sync_byte_wr_en,
  input  logic [7:0]             sync_byte_wr_data,
  rwdf_req_if.sink               req,
  input  rwdf_pkg::queue_status_t q_status,
  output logic                   push,
  output rwdf_pkg::frame_t       push_frame
);

  logic [7:0] sync_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= rwdf_pkg::SYNC_RESET;
    end else if (sync_byte_wr_en) begin
      sync_byte <= sync_byte_wr_data;
    end
  end

  assign req.ready = !q_status.full;
  assign push      = req.valid && !q_status.full;

  always_comb begin
    push_frame.sync     = sync_byte;
    push_frame.node     = req.node_address;
    push_frame.reg_byte = {1'b0, req.register_address} | rwdf_pkg::WRITE_FLAG;
    push_frame.data     = req.data_word;
  end

endmodule

[hdl/rwdf_queue.sv]
// Short queue of formatted frames between the front and back parts.
// Depends on rwdf_pkg.
module rwdf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rwdf_pkg::frame_t        push_frame,
  input  logic                    pop,
  output rwdf_pkg::frame_t        head,
  output rwdf_pkg::queue_status_t status
);

  rwdf_pkg::frame_t                entries [rwdf_pkg::QUEUE_DEPTH];
  logic [rwdf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rwdf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rwdf_pkg::QCNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rwdf_pkg::QPTR_W'(rwdf_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rwdf_pkg::QPTR_W'(rwdf_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == rwdf_pkg::QCNT_W'(rwdf_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

[hdl/rwdf_back.sv]
// Back part: sends the head frame one byte a cycle while the output is not stalled, with a running CRC-8.
// Depends on rwdf_pkg and rwdf_byte_if.
module rwdf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rwdf_pkg::frame_t        head,
  input  rwdf_pkg::queue_status_t q_status,
  output logic                    pop,
  output rwdf_pkg::back_status_t  status,
  rwdf_byte_if.source             rsp
);

  logic [2:0] pos;
  logic [7:0] crc;
  logic [7:0] cur_byte;
  logic       advance;
  logic       emit;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  always_comb begin
    case (pos)
      rwdf_pkg::POS_SYNC:  cur_byte = head.sync;
      rwdf_pkg::POS_NODE:  cur_byte = head.node;
      rwdf_pkg::POS_REG:   cur_byte = head.reg_byte;
      rwdf_pkg::POS_DATA3: cur_byte = head.data[31:24];
      rwdf_pkg::POS_DATA2: cur_byte = head.data[23:16];
      rwdf_pkg::POS_DATA1: cur_byte = head.data[15:8];
      rwdf_pkg::POS_DATA0: cur_byte = head.data[7:0];
      default:             cur_byte = crc;
    endcase
  end

  assign advance = !out_valid || rsp.ready;
  assign emit    = advance && !q_status.empty;
  assign pop     = emit && (pos == rwdf_pkg::POS_CRC);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= rwdf_pkg::POS_SYNC;
      crc       <= 8'h00;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= !q_status.empty;
      end
      if (emit) begin
        if (pos == rwdf_pkg::POS_CRC) begin
          pos <= rwdf_pkg::POS_SYNC;
          crc <= 8'h00;
        end else begin
          pos <= pos + 3'd1;
          crc <= rwdf_pkg::crc8_byte(crc, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cur_byte;
      out_last <= (pos == rwdf_pkg::POS_CRC);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_byte  = out_byte;
  assign rsp.last_byte = out_last;
  assign status.pos    = pos;

endmodule

[hdl/register_write_datagram_framer.sv]
// Top level of the register write datagram framer: front, queue and back part.
// Depends on rwdf_pkg, the channel interfaces and the assertion macro header.
//
// Channel      Direction  Moves
// req          in         one register write request (node, register, data)
// rsp          out        one datagram byte, last_byte set on the CRC byte
// sync_byte_*  in        write of the sync byte register
//
// Each request yields eight bytes, sent through the byte-wide output register
// of the back part.
// The first byte of a request passes through the queue and then the output register.
// Reset sets the sync byte to 0x05 and empties the queue and output register.
// A stalled output holds its byte; requests are taken until two frames wait.
`include "register_write_datagram_framer_defines.svh"

module register_write_datagram_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        sync_byte_wr_en,
  input  logic [7:0]  sync_byte_wr_data,
  rwdf_req_if.sink    req,
  rwdf_byte_if.source rsp
);

  logic                    push;
  logic                    pop;
  rwdf_pkg::frame_t        push_frame;
  rwdf_pkg::frame_t        head;
  rwdf_pkg::queue_status_t q_status;
  rwdf_pkg::back_status_t  b_status;

  rwdf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .sync_byte_wr_en   (sync_byte_wr_en),
    .sync_byte_wr_data (sync_byte_wr_data),
    .req               (req),
    .q_status          (q_status),
    .push              (push),
    .push_frame        (push_frame)
  );

  rwdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  rwdf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .status   (b_status),
    .rsp      (rsp)
  );

  `RWDF_ASSERT_IMPLIES(a_head_held, clk, rst, b_status.pos != rwdf_pkg::POS_SYNC, !q_status.empty, "frame left the queue before its CRC byte")
  `RWDF_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, q_status.count <= rwdf_pkg::QCNT_W'(rwdf_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `RWDF_ASSERT_NEXT(a_push_fills, clk, rst, push && q_status.empty, !q_status.empty, "accepted request not queued")

endmodule

[tb/register_write_datagram_framer_tb.sv]
// Self-checking testbench for register_write_datagram_framer: register write
// requests in, eight checked datagram bytes out per request, with random pacing.
// Depends on rwdf_pkg, the rwdf_req_if and rwdf_byte_if interfaces, and the RTL.
module register_write_datagram_framer_tb;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } datagram_byte_t;

  logic       clk;
  logic       rst;
  logic       sync_byte_wr_en;
  logic [7:0] sync_byte_wr_data;

  rwdf_req_if  req_ch();
  rwdf_byte_if rsp_ch();

  register_write_datagram_framer dut (
    .clk(clk),
    .rst(rst),
    .sync_byte_wr_en(sync_byte_wr_en),
    .sync_byte_wr_data(sync_byte_wr_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  datagram_byte_t pending_bytes[$];
  logic [7:0]     sync_shadow;
  int             error_count;
  bit             paced;
  int             rsp_hold_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // The CRC register shifts left while each byte enters least significant bit first.
  function automatic logic [7:0] datagram_crc(input logic [55:0] body);
    logic [7:0] crc;
    logic       feedback;
    crc = 8'h00;
    for (int i = 6; i >= 0; i--) begin
      for (int b = 0; b < 8; b++) begin
        feedback = body[i * 8 + b] ^ crc[7];
        crc = {crc[6:0], 1'b0};
        if (feedback) begin
          crc = crc ^ rwdf_pkg::CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  task automatic predict_datagram(input logic [7:0] node, input logic [6:0] reg_addr,
                                  input logic [31:0] data);
    logic [55:0]    body;
    datagram_byte_t entry;
    body = {sync_shadow, node, rwdf_pkg::WRITE_FLAG | {1'b0, reg_addr}, data};
    for (int i = 6; i >= 0; i--) begin
      entry.value = body[i * 8 +: 8];
      entry.last  = 1'b0;
      pending_bytes.push_back(entry);
    end
    entry.value = datagram_crc(body);
    entry.last  = 1'b1;
    pending_bytes.push_back(entry);
  endtask

  // Returns at the edge where the request was taken; valid is left high.
  task automatic send_write_request(input logic [7:0] node, input logic [6:0] reg_addr,
                                    input logic [31:0] data);
    int gap;
    gap = paced ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.node_address     <= node;
    req_ch.register_address <= reg_addr;
    req_ch.data_word        <= data;
    do @(posedge clk); while (!req_ch.ready);
    predict_datagram(node, reg_addr, data);
  endtask

  task automatic drain_datagrams();
    req_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync_byte(input logic [7:0] value);
    drain_datagrams();
    sync_byte_wr_en   <= 1'b1;
    sync_byte_wr_data <= value;
    @(posedge clk);
    sync_shadow = value;
    sync_byte_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    datagram_byte_t expected;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual 8'h%02h last %0b",
                 $time, rsp_ch.out_byte, rsp_ch.last_byte);
        error_count++;
      end else begin
        expected = pending_bytes.pop_front();
        if (rsp_ch.out_byte !== expected.value) begin
          $display("%0t: out_byte mismatch: expected 8'h%02h, actual 8'h%02h",
                   $time, expected.value, rsp_ch.out_byte);
          error_count++;
        end
        if (rsp_ch.last_byte !== expected.last) begin
          $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                   $time, expected.last, rsp_ch.last_byte);
          error_count++;
        end
      end
    end
  end

  // The receiver draws a stall for every byte and honors a long hold when asked.
  initial begin : receiver
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < rsp_hold_cycles; n++) @(posedge clk);
        rsp_hold_cycles = 0;
      end
      stall = paced ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic test_reset_sync();
    send_write_request(8'h00, 7'h00, 32'h0000_0000);
    send_write_request(8'hff, 7'h7f, 32'hffff_ffff);
  endtask

  task automatic test_field_extremes();
    send_write_request(8'h55, 7'h55, 32'h5555_5555);
    send_write_request(8'haa, 7'h2a, 32'haaaa_aaaa);
    send_write_request(8'h01, 7'h01, 32'h0000_0001);
    send_write_request(8'h80, 7'h40, 32'h8000_0000);
    send_write_request(8'hff, 7'h00, 32'h00ff_00ff);
    send_write_request(8'h00, 7'h7f, 32'hff00_ff00);
  endtask

  task automatic test_sync_register();
    write_sync_byte(8'h00);
    send_write_request(8'h12, 7'h34, 32'hdead_beef);
    write_sync_byte(8'hff);
    send_write_request(8'hff, 7'h7f, 32'hffff_ffff);
    write_sync_byte(8'ha5);
    send_write_request(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), $urandom);
  endtask

  task automatic test_output_backpressure();
    drain_datagrams();
    paced = 1'b0;
    rsp_hold_cycles = 250;
    repeat (12) begin
      send_write_request(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), $urandom);
    end
    drain_datagrams();
  endtask

  task automatic test_random_requests();
    logic [7:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] data;
    for (int phase = 0; phase < 4; phase++) begin
      write_sync_byte(phase == 3 ? 8'h05 : 8'($urandom_range(0, 255)));
      for (int i = 0; i < 65; i++) begin
        if (i % 10 == 0) begin
          paced = ($urandom_range(0, 3) != 0);
        end
        node     = 8'($urandom_range(0, 255));
        reg_addr = 7'($urandom_range(0, 127));
        data     = $urandom;
        case ($urandom_range(0, 7))
          0: begin
            node = 8'h00;
            data = 32'h0000_0000;
          end
          1: begin
            reg_addr = 7'h7f;
            data     = 32'hffff_ffff;
          end
          default: begin
          end
        endcase
        send_write_request(node, reg_addr, data);
      end
    end
  endtask

  initial begin
    error_count     = 0;
    sync_shadow     = rwdf_pkg::SYNC_RESET;
    paced           = 1'b1;
    rsp_hold_cycles = 0;
    rst                     <= 1'b1;
    sync_byte_wr_en         <= 1'b0;
    sync_byte_wr_data       <= 8'h00;
    req_ch.valid            <= 1'b0;
    req_ch.node_address     <= 8'h00;
    req_ch.register_address <= 7'h00;
    req_ch.data_word        <= 32'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_sync();
    test_field_extremes();
    test_sync_register();
    test_output_backpressure();
    paced = 1'b1;
    test_random_requests();

    drain_datagrams();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
